[rtl/cprc_pkg.sv]
// Package for the convex polygon raster/collide block.
// Types and constants shared by controller and datapath; no dependencies.
package cprc_pkg;

    localparam int VW = 11;
    localparam int FW = 9;
    localparam int RW = 9;
    localparam int AW = 13;   // working width for coordinates
    localparam logic [RW-1:0] CLIP_RES = 9'd256;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SETUP,
        ST_EDGE,
        ST_DIV,
        ST_ROW,
        ST_SCAN,
        ST_SCAN_WAIT,
        ST_FILL,
        ST_NEXT,
        ST_LAST,
        ST_CLEAR,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic setup;
        logic edge_start;
        logic edge_load;
        logic row_begin;
        logic scan_start;
        logic scan_step;
        logic fill_step;
        logic row_advance;
        logic final_fill;
        logic clear_step;
        logic done;
    } cmd_t;

    typedef struct packed {
        logic div_done;
        logic edge_last;
        logic row_last;
        logic scan_end;
        logic fill_end;
        logic fill_skip;
        logic clear_end;
    } stat_t;

endpackage

[rtl/convex_polygon_raster_collide_top.sv]
// Convex quadrilateral scanline fill with collision test, top level.
// Depends on cprc_pkg, cprc_ctrl, cprc_datapath, cprc_div.
//
// Usage: present four counter-clockwise vertices and fill_value, raise start
// while busy is low; the transaction is taken at that edge. The block walks
// the rows of the polygon clipped to a FIELD_DIM x FIELD_DIM field of 8-bit
// cells. Per row it runs each edge's crossing through one shared bit-serial
// divider (an edge that misses the row does not wait for it), then reads the
// interior window of the previous row one cell a cycle from the single field
// memory port, then writes that row's span one cell a cycle. One polygon is
// processed at a time.
// max_overlap is shown with done high for exactly one cycle; the receiver
// cannot stall it. 256 means clipping occurred.
// Reset: the field memory is cleared by a pass over every cell address
// (FIELD_DIM rounded up to a power of two, then squared), during which busy
// stays high.
module convex_polygon_raster_collide_top #(
    parameter int FIELD_DIM = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic signed [10:0] v0_x,
    input  logic signed [10:0] v0_y,
    input  logic signed [10:0] v1_x,
    input  logic signed [10:0] v1_y,
    input  logic signed [10:0] v2_x,
    input  logic signed [10:0] v2_y,
    input  logic signed [10:0] v3_x,
    input  logic signed [10:0] v3_y,
    input  logic signed [8:0]  fill_value,
    output logic        done,
    output logic [8:0]  max_overlap
);
    cprc_pkg::cmd_t  cmd;
    cprc_pkg::stat_t stat;
    logic load;
    logic signed [cprc_pkg::VW-1:0] vx [4];
    logic signed [cprc_pkg::VW-1:0] vy [4];

    assign vx[0] = v0_x;
    assign vx[1] = v1_x;
    assign vx[2] = v2_x;
    assign vx[3] = v3_x;
    assign vy[0] = v0_y;
    assign vy[1] = v1_y;
    assign vy[2] = v2_y;
    assign vy[3] = v3_y;

    cprc_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .stat   (stat),
        .cmd    (cmd),
        .busy   (busy),
        .load   (load),
        .strobe (done)
    );

    cprc_datapath #(.FIELD_DIM(FIELD_DIM)) u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .load    (load),
        .vx      (vx),
        .vy      (vy),
        .fill_in (fill_value),
        .cmd     (cmd),
        .stat    (stat),
        .result  (max_overlap)
    );

endmodule

[rtl/cprc_div.sv]
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
// Self-contained; depends on no other file.
module cprc_div #(
    parameter int NW = 24,
    parameter int DW = 13
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic signed [NW-1:0] num,
    input  logic signed [DW-1:0] den,
    output logic                 done,
    output logic signed [NW-1:0] quo
);
    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] q_reg, q_next;
    logic [DW:0]   r_reg, r_next;
    logic [DW-1:0] d_reg, d_next;
    logic          neg_reg, neg_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          run_reg, run_next;
    logic          done_reg, done_next;
    logic [DW:0]   trial;

    always_comb
    begin
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        trial     = {r_reg[DW-1:0], q_reg[NW-1]} - {1'b0, d_reg};
        if (start)
        begin
            q_next   = num[NW-1] ? NW'(-num) : NW'(num);
            d_next   = den[DW-1] ? DW'(-den) : DW'(den);
            neg_next = num[NW-1] ^ den[DW-1];
            r_next   = '0;
            cnt_next = CW'(NW);
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            if (!trial[DW])
            begin
                r_next = trial;
                q_next = {q_reg[NW-2:0], 1'b1};
            end
            else
            begin
                r_next = {r_reg[DW-1:0], q_reg[NW-1]};
                q_next = {q_reg[NW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        r_reg   <= r_next;
        d_reg   <= d_next;
        neg_reg <= neg_next;
    end

    assign done = done_reg;
    assign quo  = neg_reg ? NW'(-q_reg) : NW'(q_reg);

endmodule

[rtl/cprc_datapath.sv]
// Datapath: vertex registers, edge crossing unit, span registers, field memory.
// Depends on cprc_pkg and cprc_div.
module cprc_datapath #(
    parameter int FIELD_DIM = 256
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         load,
    input  logic signed [cprc_pkg::VW-1:0] vx [4],
    input  logic signed [cprc_pkg::VW-1:0] vy [4],
    input  logic signed [cprc_pkg::FW-1:0] fill_in,
    input  cprc_pkg::cmd_t               cmd,
    output cprc_pkg::stat_t              stat,
    output logic [cprc_pkg::RW-1:0]      result
);
    localparam int AW = cprc_pkg::AW;
    localparam int CB = $clog2(FIELD_DIM);
    localparam int MA = 2 * CB;
    localparam int MD = 1 << MA;   // row and column fields each take CB bits
    localparam int NW = 24;

    logic signed [cprc_pkg::VW-1:0] px_reg [4];
    logic signed [cprc_pkg::VW-1:0] py_reg [4];
    logic signed [cprc_pkg::FW-1:0] val_reg;
    logic [cprc_pkg::RW-1:0] res_reg, res_next;
    logic signed [AW-1:0] y_reg, yhi_reg;
    logic signed [AW-1:0] prv1_reg, prv2_reg, cur1_reg, cur2_reg, nxt1_reg, nxt2_reg;
    logic signed [AW-1:0] h2_reg, x_reg;
    logic [1:0] e_reg;
    logic       side_reg, hit_reg;
    logic signed [AW-1:0] base_reg;
    logic [MA:0] clr_reg;

    logic [7:0] mem [MD];
    logic [7:0] rd_reg;
    logic       rd_valid_reg;

    // edge setup for current edge index
    logic signed [AW-1:0] ax, ay, bx, by, sx, sy, tx, ty, dx, dy;
    logic                 swap, up, dn;
    logic signed [NW-1:0] prod;
    logic                 div_done;
    logic signed [NW-1:0] quo;

    always_comb
    begin
        ax   = AW'(px_reg[e_reg]);
        ay   = AW'(py_reg[e_reg]);
        bx   = AW'(px_reg[e_reg + 2'd1]);
        by   = AW'(py_reg[e_reg + 2'd1]);
        up   = (ay <= y_reg) && (by >= y_reg);
        dn   = (ay >= y_reg) && (by <= y_reg);
        swap = (ax > bx) || ((ax == bx) && (ay > by));
        sx   = swap ? bx : ax;
        sy   = swap ? by : ay;
        tx   = swap ? ax : bx;
        ty   = swap ? ay : by;
        dx   = tx - sx + ((sx <= tx) ? AW'(1) : -AW'(1));
        dy   = ty - sy + ((sy <= ty) ? AW'(1) : -AW'(1));
        prod = NW'(y_reg - sy) * NW'(dx);
    end

    cprc_div #(.NW(NW), .DW(AW)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.edge_start && (up || dn)),
        .num   (prod),
        .den   (dy),
        .done  (div_done),
        .quo   (quo)
    );

    // memory addressing
    logic [MA-1:0] addr;
    logic signed [AW-1:0] row_m1, fill_row;
    logic fill_ok, do_write, do_read;
    logic [7:0] wdata;

    assign row_m1   = y_reg - AW'(1);
    assign fill_row = cmd.final_fill ? y_reg - AW'(1) : row_m1;
    assign fill_ok  = !val_reg[cprc_pkg::FW-1] && (fill_row >= 0) && (fill_row < AW'(FIELD_DIM));
    assign do_write = (cmd.fill_step && fill_ok && (x_reg <= cur2_reg)) || cmd.clear_step;
    assign do_read  = cmd.scan_step && (x_reg <= h2_reg);
    assign wdata    = cmd.clear_step ? 8'd0 : val_reg[7:0];

    always_comb
    begin
        if (cmd.clear_step)
            addr = clr_reg[MA-1:0];
        else
            addr = {row_m1[CB-1:0], x_reg[CB-1:0]};
    end

    always_ff @(posedge clk)
    begin
        if (do_write)
            mem[addr] <= wdata;
        rd_reg <= mem[addr];
    end

    // span bounds
    logic signed [AW-1:0] h1c, h2c, n1c, n2c;
    always_comb
    begin
        n1c = nxt1_reg;
        n2c = nxt2_reg;
        h1c = cur1_reg + AW'(1);
        h2c = cur2_reg - AW'(1);
        if (prv1_reg > h1c) h1c = prv1_reg;
        if (n1c > h1c) h1c = n1c;
        if (prv2_reg < h2c) h2c = prv2_reg;
        if (n2c < h2c) h2c = n2c;
    end

    // y range
    logic signed [AW-1:0] ylo_c, yhi_c;
    always_comb
    begin
        ylo_c = AW'(vy[0]);
        yhi_c = AW'(vy[0]);
        for (int i = 1; i < 4; i++)
        begin
            if (AW'(vy[i]) < ylo_c) ylo_c = AW'(vy[i]);
            if (AW'(vy[i]) > yhi_c) yhi_c = AW'(vy[i]);
        end
    end

    // running maximum; row clipping at setup and column clipping per row force 256
    always_comb
    begin
        res_next = res_reg;
        if (rd_valid_reg && ({1'b0, rd_reg} > res_reg))
            res_next = {1'b0, rd_reg};
        if (load)
            res_next = '0;
        if (cmd.setup && ((y_reg < 0) || (yhi_reg >= AW'(FIELD_DIM))))
            res_next = cprc_pkg::CLIP_RES;
        if (cmd.scan_start && ((nxt1_reg < 0) || (nxt2_reg >= AW'(FIELD_DIM))))
            res_next = cprc_pkg::CLIP_RES;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg      <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= do_read;
            if (cmd.clear_step)
                clr_reg <= clr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        if (load)
        begin
            px_reg  <= vx;
            py_reg  <= vy;
            val_reg <= fill_in;
            y_reg   <= ylo_c;
            yhi_reg <= yhi_c;
        end
        if (cmd.setup)
        begin
            prv1_reg <= AW'(1);
            cur1_reg <= AW'(1);
            prv2_reg <= '0;
            cur2_reg <= '0;
            nxt1_reg <= '0;
            nxt2_reg <= -AW'(1);
            if (y_reg < 0)
                y_reg <= '0;
            if (yhi_reg >= AW'(FIELD_DIM))
                yhi_reg <= AW'(FIELD_DIM - 1);
        end
        if (cmd.row_begin)
            e_reg <= 2'd0;
        if (cmd.edge_start)
        begin
            side_reg <= up;
            hit_reg  <= up || dn;
            base_reg <= sx;
        end
        if (cmd.edge_load)
        begin
            if (hit_reg)
            begin
                if (side_reg)
                    nxt1_reg <= base_reg + AW'(quo);
                else
                    nxt2_reg <= base_reg + AW'(quo);
            end
            e_reg <= e_reg + 2'd1;
        end
        if (cmd.scan_start)
        begin
            // clip the new crossings before forming the read window
            if (nxt1_reg < 0)
                nxt1_reg <= '0;
            if (nxt2_reg >= AW'(FIELD_DIM))
                nxt2_reg <= AW'(FIELD_DIM - 1);
        end
        if (cmd.row_advance && !cmd.scan_step)
        begin
            h2_reg <= h2c;
            x_reg  <= h1c;
        end
        if (cmd.scan_step)
            x_reg <= x_reg + AW'(1);
        if (cmd.fill_step)
            x_reg <= x_reg + AW'(1);
        if (cmd.final_fill && !cmd.fill_step)
            x_reg <= cur1_reg;
        if (cmd.done)
        begin
            prv1_reg <= cur1_reg;
            prv2_reg <= cur2_reg;
            cur1_reg <= nxt1_reg;
            cur2_reg <= nxt2_reg;
            y_reg    <= y_reg + AW'(1);
        end
        if (cmd.clear_step && !cmd.scan_step)
            x_reg <= cur1_reg;
    end

    assign stat.div_done  = div_done || !hit_reg;
    assign stat.edge_last = (e_reg == 2'd3);
    assign stat.row_last  = (y_reg > yhi_reg);
    assign stat.scan_end  = (x_reg > h2_reg) || (row_m1 < 0);
    assign stat.fill_end  = (x_reg > cur2_reg);
    assign stat.fill_skip = !fill_ok;
    assign stat.clear_end = clr_reg[MA];
    assign result         = res_reg;

endmodule

[rtl/cprc_ctrl.sv]
// Controller FSM: clearing pass, per-row edge divisions, read scan, fill.
// Depends on cprc_pkg.
module cprc_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  cprc_pkg::stat_t stat,
    output cprc_pkg::cmd_t  cmd,
    output logic            busy,
    output logic            load,
    output logic            strobe
);
    cprc_pkg::state_t state_reg, state_next;
    logic rd_tail_reg, rd_tail_next;

    always_comb
    begin
        state_next   = state_reg;
        rd_tail_next = 1'b0;
        cmd          = '0;
        load         = 1'b0;
        strobe       = 1'b0;
        busy         = 1'b1;
        case (state_reg)
            cprc_pkg::ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (stat.clear_end)
                    state_next = cprc_pkg::ST_IDLE;
            end
            cprc_pkg::ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    load       = 1'b1;
                    state_next = cprc_pkg::ST_SETUP;
                end
            end
            cprc_pkg::ST_SETUP:
            begin
                cmd.setup  = 1'b1;
                state_next = cprc_pkg::ST_ROW;
            end
            cprc_pkg::ST_ROW:
            begin
                if (stat.row_last)
                    state_next = cprc_pkg::ST_LAST;
                else
                begin
                    cmd.row_begin = 1'b1;
                    state_next    = cprc_pkg::ST_EDGE;
                end
            end
            cprc_pkg::ST_EDGE:
            begin
                cmd.edge_start = 1'b1;
                state_next     = cprc_pkg::ST_DIV;
            end
            cprc_pkg::ST_DIV:
            begin
                if (stat.div_done)
                begin
                    cmd.edge_load = 1'b1;
                    state_next    = stat.edge_last ? cprc_pkg::ST_NEXT : cprc_pkg::ST_EDGE;
                end
            end
            cprc_pkg::ST_NEXT:
            begin
                cmd.scan_start = 1'b1;
                state_next     = cprc_pkg::ST_SCAN_WAIT;
            end
            cprc_pkg::ST_SCAN_WAIT:
            begin
                cmd.row_advance = 1'b1;
                state_next      = cprc_pkg::ST_SCAN;
            end
            cprc_pkg::ST_SCAN:
            begin
                if (stat.scan_end)
                begin
                    if (!rd_tail_reg)
                    begin
                        cmd.final_fill = 1'b1;
                        state_next     = cprc_pkg::ST_FILL;
                    end
                end
                else
                begin
                    cmd.scan_step = 1'b1;
                    rd_tail_next  = 1'b1;
                end
            end
            cprc_pkg::ST_FILL:
            begin
                if (stat.fill_end || stat.fill_skip)
                begin
                    cmd.done   = 1'b1;
                    state_next = cprc_pkg::ST_ROW;
                end
                else
                    cmd.fill_step = 1'b1;
            end
            cprc_pkg::ST_LAST:
            begin
                cmd.final_fill = 1'b1;
                state_next     = cprc_pkg::ST_DONE;
            end
            cprc_pkg::ST_DONE:
            begin
                if (stat.fill_end || stat.fill_skip)
                    strobe = 1'b1;
                else
                    cmd.fill_step = 1'b1;
                if (stat.fill_end || stat.fill_skip)
                    state_next = cprc_pkg::ST_IDLE;
            end
            default:
                state_next = cprc_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= cprc_pkg::ST_CLEAR;
            rd_tail_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            rd_tail_reg <= rd_tail_next;
        end
    end

`ifndef SYNTHESIS
    a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> busy) else $error("strobe while idle");
    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> (state_reg == cprc_pkg::ST_SETUP)) else $error("load not followed by setup");
    a_no_write_scan: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.scan_step && cmd.fill_step)) else $error("scan and fill overlap");
`endif

endmodule
